// ----- rtl/mlr_pkg.sv -----
// Shared types and constants for the midpoint line rasteriser.
package mlr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 4;

    localparam int S_TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } t_func;

    // bit 1: y is the major axis; bit 0: minor axis steps down
    typedef struct packed {
        logic steep;
        logic minor_neg;
    } t_slope_class;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] major_end;
        logic signed [DEC_BITS-1:0]   decision;
        logic signed [DEC_BITS-1:0]   inc_straight;
        logic signed [DEC_BITS-1:0]   inc_diagonal;
        t_slope_class                 slope;
        logic                         active;
    } t_line_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
        logic                         none;
    } t_pixel;

    typedef struct packed {
        t_func                        func;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_request;

endpackage

// ----- rtl/midpoint_line_rasterizer_core.sv -----
// Midpoint line rasteriser top level: request register, line state, result register.
//
// Integer midpoint (Bresenham) line rasteriser with a pull interface. A start
// request (tuser = 0) carries two endpoints in tdata and returns the first
// pixel; every advance request (tuser = 1) returns the next pixel, and the
// pixel on the far endpoint comes with tlast high, after which the line is
// over. An advance with no line active returns one result with tuser high and
// zero coordinates. A start while a line is running drops the old line. Each
// request yields exactly one result. Throughput is one request per clock
// while the result channel is not stalled: a request is registered, then the
// set-up or step logic (the step adds an increment to the decision value and
// compares the major coordinate with the far end) updates the line state and
// loads the result register at the same edge. A request waits in the request
// register until the result register is free. The request register is refilled
// while the result register waits to be taken; tready falls only when both hold
// an item and the downstream side is stalled.
module midpoint_line_rasterizer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: start_x, start_y, end_x, end_y (lowest bits first)
    input  logic [mlr_pkg::S_TDATA_BITS-1:0]  i_s_tdata,
    // tuser: func (0 start, 1 advance)
    input  logic                              i_s_tuser,
    // result channel
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: pixel_x, pixel_y (lowest bits first), zero padded
    output logic [mlr_pkg::M_TDATA_BITS-1:0]  o_m_tdata,
    // tlast: last_pixel
    output logic                              o_m_tlast,
    // tuser: no_pixel
    output logic                              o_m_tuser
);

    localparam int CB = mlr_pkg::COORD_BITS;

    // request register
    logic              r_in_valid;
    logic              n_in_valid;
    mlr_pkg::t_request r_in;

    // line state
    mlr_pkg::t_line_state r_line;
    mlr_pkg::t_line_state n_line;

    // result register
    logic            r_out_valid;
    logic            n_out_valid;
    mlr_pkg::t_pixel r_out;
    mlr_pkg::t_pixel n_out;

    mlr_pkg::t_line_state setup_state;
    mlr_pkg::t_pixel      setup_pixel;
    mlr_pkg::t_line_state step_state;
    mlr_pkg::t_pixel      step_pixel;

    logic out_free;
    logic proc;
    logic s_accept;

    mlr_setup u_setup (
        .i_x0    (r_in.start_x),
        .i_y0    (r_in.start_y),
        .i_x1    (r_in.end_x),
        .i_y1    (r_in.end_y),
        .o_state (setup_state),
        .o_pixel (setup_pixel)
    );

    mlr_step u_step (
        .i_state (r_line),
        .o_state (step_state),
        .o_pixel (step_pixel)
    );

    // result slot is free when empty or being drained this cycle
    assign out_free   = ~r_out_valid | i_m_tready;
    assign proc       = r_in_valid & out_free;
    assign o_s_tready = ~r_in_valid | out_free;
    assign s_accept   = i_s_tvalid & o_s_tready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        n_line      = r_line;
        n_out       = r_out;

        if (s_accept) begin
            n_in_valid = 1'b1;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end

        if (proc) begin
            n_out_valid = 1'b1;
            if (r_in.func == mlr_pkg::FUNC_START) begin
                n_line = setup_state;
                n_out  = setup_pixel;
            end else begin
                n_line = step_state;
                n_out  = step_pixel;
            end
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_line      <= n_line;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.func    <= mlr_pkg::t_func'(i_s_tuser);
            r_in.start_x <= i_s_tdata[CB-1:0];
            r_in.start_y <= i_s_tdata[2*CB-1:CB];
            r_in.end_x   <= i_s_tdata[3*CB-1:2*CB];
            r_in.end_y   <= i_s_tdata[4*CB-1:3*CB];
        end
        r_out <= n_out;
    end

    always_comb begin
        o_m_tdata           = '0;
        o_m_tdata[CB-1:0]   = r_out.x;
        o_m_tdata[2*CB-1:CB] = r_out.y;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.last;
    assign o_m_tuser  = r_out.none;

endmodule

// ----- rtl/mlr_setup.sv -----
// Line set-up: slope class, endpoint ordering, decision value and first pixel.
module mlr_setup (
    input  logic signed [mlr_pkg::COORD_BITS-1:0] i_x0,
    input  logic signed [mlr_pkg::COORD_BITS-1:0] i_y0,
    input  logic signed [mlr_pkg::COORD_BITS-1:0] i_x1,
    input  logic signed [mlr_pkg::COORD_BITS-1:0] i_y1,
    output mlr_pkg::t_line_state                  o_state,
    output mlr_pkg::t_pixel                       o_pixel
);

    localparam int CB  = mlr_pkg::COORD_BITS;
    localparam int DB  = mlr_pkg::DELTA_BITS;
    localparam int EB  = mlr_pkg::DEC_BITS;

    logic signed [DB-1:0] dx;
    logic signed [DB-1:0] dy;
    logic signed [DB-1:0] adx;
    logic signed [DB-1:0] ady;
    logic                 steep;
    logic                 swap;
    logic                 minor_neg;
    logic signed [DB-1:0] len_major;
    logic signed [DB-1:0] len_minor;
    logic signed [EB-1:0] major_ext;
    logic signed [EB-1:0] minor2;

    always_comb begin
        dx  = $signed({i_x1[CB-1], i_x1}) - $signed({i_x0[CB-1], i_x0});
        dy  = $signed({i_y1[CB-1], i_y1}) - $signed({i_y0[CB-1], i_y0});
        adx = dx[DB-1] ? -dx : dx;
        ady = dy[DB-1] ? -dy : dy;

        // tie on |dx| = |dy| counts as shallow
        steep = ady > adx;
        // order endpoints so the major axis counts up
        swap  = steep ? dy[DB-1] : dx[DB-1];

        // sign of the minor delta after ordering; zero counts as rising
        if (steep) begin
            minor_neg = swap ? (dx > 0) : dx[DB-1];
        end else begin
            minor_neg = swap ? (dy > 0) : dy[DB-1];
        end

        len_major = steep ? ady : adx;
        len_minor = steep ? adx : ady;
        major_ext = $signed({{(EB-DB){1'b0}}, len_major});
        minor2    = $signed({{(EB-DB-1){1'b0}}, len_minor, 1'b0});

        o_state.cur_x        = swap ? i_x1 : i_x0;
        o_state.cur_y        = swap ? i_y1 : i_y0;
        if (steep) begin
            o_state.major_end = swap ? i_y0 : i_y1;
        end else begin
            o_state.major_end = swap ? i_x0 : i_x1;
        end
        o_state.decision     = minor2 - major_ext;
        o_state.inc_straight = minor2;
        o_state.inc_diagonal = minor2 - (major_ext <<< 1);
        o_state.slope.steep     = steep;
        o_state.slope.minor_neg = minor_neg;
        o_state.active       = (len_major != '0);

        o_pixel.x    = o_state.cur_x;
        o_pixel.y    = o_state.cur_y;
        o_pixel.last = (len_major == '0);
        o_pixel.none = 1'b0;
    end

endmodule

// ----- rtl/mlr_step.sv -----
// One midpoint step along the major axis, with the end-of-line check.
module mlr_step (
    input  mlr_pkg::t_line_state i_state,
    output mlr_pkg::t_line_state o_state,
    output mlr_pkg::t_pixel      o_pixel
);

    localparam int CB = mlr_pkg::COORD_BITS;

    logic                 diag;
    logic signed [CB-1:0] minor_step;
    logic signed [CB-1:0] major_now;
    logic                 at_end;

    always_comb begin
        o_state    = i_state;
        diag       = ~i_state.decision[mlr_pkg::DEC_BITS-1];
        minor_step = i_state.slope.minor_neg ? -CB'(1) : CB'(1);
        major_now  = '0;
        at_end     = 1'b0;

        o_pixel.x    = '0;
        o_pixel.y    = '0;
        o_pixel.last = 1'b0;
        o_pixel.none = 1'b1;

        if (i_state.active) begin
            o_state.decision = i_state.decision
                             + (diag ? i_state.inc_diagonal : i_state.inc_straight);
            if (i_state.slope.steep) begin
                major_now       = i_state.cur_y + CB'(1);
                o_state.cur_y   = major_now;
                o_state.cur_x   = diag ? i_state.cur_x + minor_step : i_state.cur_x;
            end else begin
                major_now       = i_state.cur_x + CB'(1);
                o_state.cur_x   = major_now;
                o_state.cur_y   = diag ? i_state.cur_y + minor_step : i_state.cur_y;
            end
            at_end         = ($signed(major_now) >= $signed(i_state.major_end));
            o_state.active = ~at_end;

            o_pixel.x    = o_state.cur_x;
            o_pixel.y    = o_state.cur_y;
            o_pixel.last = at_end;
            o_pixel.none = 1'b0;
        end
    end

endmodule
